/* hdl/dqir_pkg.sv */
// Shared types and codes for the indexed-read deque.
// Command and status encodings and fixed field widths; no dependencies.
`timescale 1ns / 1ps

package dqir_pkg;

	localparam int CMD_BITS    = 3;
	localparam int POS_BITS    = 8;
	localparam int STATUS_BITS = 2;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_READ_POS   = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_POP_BACK   = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK   = 2'd0,
		ST_ERR  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

endpackage

/* hdl/dqir_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; contents are not reset.
`timescale 1ns / 1ps

module dqir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on request, register read data on read enable
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/deque_with_indexed_read_unit.sv */
// A result is valid in the cycle after its command transaction is accepted.
// One command per cycle while the result is not stalled; each command uses at most
// one write or one read of the entry RAM; front index and count update together.
// Reset: front index, count and the result valid clear at once; the entry RAM is
// not cleared and needs no clearing pass, as only held entries are ever read.
`timescale 1ns / 1ps

module deque_with_indexed_read_unit
	import dqir_pkg::*;
#(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32,
	localparam int AW       = $clog2(DEPTH),
	localparam int CW       = $clog2(DEPTH + 1),
	localparam int IN_W     = ((CMD_BITS + WORD_BITS + POS_BITS + 7) / 8) * 8,
	localparam int OUT_W    = ((STATUS_BITS + WORD_BITS + CW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // cmd, data_word, position, zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // status, read_word, count, zero pad
);

	localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

	cmd_t                  cmd_in;
	logic [WORD_BITS-1:0]  word_in;
	logic [POS_BITS-1:0]   pos_in;

	logic [AW-1:0]         front_q;
	logic [CW-1:0]         count_q;
	logic                  m_tvalid_q;

	status_t               status_s1;
	logic [CW-1:0]         count_s1;
	logic                  rd_ok_s1;
	logic [WORD_BITS-1:0]  ram_rdata;

	logic                  accept;
	logic                  full;
	logic                  empty;
	logic                  pos_neg;
	logic [POS_BITS-1:0]   pos_mag;
	logic [CMPW-1:0]       mag_ext;
	logic [CMPW-1:0]       cnt_ext;
	logic [CMPW-1:0]       off_ext;
	logic                  pos_ok;
	logic [AW-1:0]         offset;
	logic [AW:0]           slot_sum;
	logic [AW-1:0]         slot;
	logic [AW-1:0]         front_dec;
	logic [AW-1:0]         front_inc;

	logic [AW-1:0]         front_nxt;
	logic [CW-1:0]         count_nxt;
	status_t               status_nxt;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic                  rd_en;

	// Unpack the command transaction
	assign cmd_in  = cmd_t'(s_tdata[CMD_BITS-1:0]);
	assign word_in = s_tdata[CMD_BITS +: WORD_BITS];
	assign pos_in  = s_tdata[CMD_BITS + WORD_BITS +: POS_BITS];

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !m_tvalid_q || m_tready;
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);

	// Position magnitude and bounds check against the held count
	assign pos_neg = pos_in[POS_BITS-1];
	assign pos_mag = pos_neg ? (~pos_in + POS_BITS'(1)) : pos_in;
	assign mag_ext = CMPW'(pos_mag);
	assign cnt_ext = CMPW'(count_q);
	assign pos_ok  = (pos_mag != '0) && (mag_ext <= cnt_ext);
	assign off_ext = pos_neg ? (cnt_ext - mag_ext) : (mag_ext - CMPW'(1));

	// Slot = front + offset, wrapped once around the ring
	assign offset   = (cmd_in == CMD_PUSH_BACK) ? count_q[AW-1:0] : off_ext[AW-1:0];
	assign slot_sum = {1'b0, front_q} + {1'b0, offset};
	assign slot     = (slot_sum >= (AW+1)'(DEPTH)) ?
		AW'(slot_sum - (AW+1)'(DEPTH)) : slot_sum[AW-1:0];

	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : (front_q - AW'(1));
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : (front_q + AW'(1));

	// Decode the command into state update, RAM access and status
	always_comb begin
		front_nxt  = front_q;
		count_nxt  = count_q;
		status_nxt = ST_OK;
		wr_en      = 1'b0;
		wr_addr    = slot;
		rd_en      = 1'b0;
		unique case (cmd_in)
			CMD_PUSH_BACK: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					wr_en     = 1'b1;
					count_nxt = count_q + CW'(1);
				end
			end
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					wr_en     = 1'b1;
					wr_addr   = front_dec;
					front_nxt = front_dec;
					count_nxt = count_q + CW'(1);
				end
			end
			CMD_READ_POS: begin
				if (pos_ok) begin
					rd_en = 1'b1;
				end else begin
					status_nxt = ST_ERR;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status_nxt = ST_ERR;
				end else begin
					front_nxt = front_inc;
					count_nxt = count_q - CW'(1);
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					status_nxt = ST_ERR;
				end else begin
					count_nxt = count_q - CW'(1);
				end
			end
			default: begin
				status_nxt = ST_ERR;
			end
		endcase
	end

	// Entry store
	dqir_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (accept && wr_en),
		.waddr(wr_addr),
		.wdata(word_in),
		.re   (accept && rd_en),
		.raddr(slot),
		.rdata(ram_rdata)
	);

	// Hold ring state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				front_q <= front_nxt;
				count_q <= count_nxt;
			end
			if (s_tready) begin
				m_tvalid_q <= s_tvalid;
			end
		end
	end

	// Capture the result payload on each accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_nxt;
			count_s1  <= count_nxt;
			rd_ok_s1  <= rd_en;
		end
	end

	// Pack the result transaction
	assign m_tvalid = m_tvalid_q;
	always_comb begin
		m_tdata = '0;
		m_tdata[STATUS_BITS-1:0]                 = status_s1;
		m_tdata[STATUS_BITS +: WORD_BITS]        = rd_ok_s1 ? ram_rdata : '0;
		m_tdata[STATUS_BITS + WORD_BITS +: CW]   = count_s1;
	end

endmodule

/* hdl/dqir_checker.sv */
// Port-level checks for the indexed-read deque, bound to the top level.
// Depends on dqir_pkg for status codes and field widths.
`timescale 1ns / 1ps

module dqir_checker
	import dqir_pkg::*;
#(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32,
	localparam int CW       = $clog2(DEPTH + 1),
	localparam int OUT_W    = ((STATUS_BITS + WORD_BITS + CW + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata   // status, read_word, count, zero pad
);

	logic [STATUS_BITS-1:0] st;
	logic [WORD_BITS-1:0]   rword;
	logic [CW-1:0]          cnt;

	assign st    = m_tdata[STATUS_BITS-1:0];
	assign rword = m_tdata[STATUS_BITS +: WORD_BITS];
	assign cnt   = m_tdata[STATUS_BITS + WORD_BITS +: CW];

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Every accepted command yields a result on the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after accepted command");

	// Count stays within capacity
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt <= CW'(DEPTH))
		else $error("count beyond capacity");

	// Refused push only when full
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == ST_FULL |-> cnt == CW'(DEPTH))
		else $error("full status with room left");

	// Failed commands return no data
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st != ST_OK |-> rword == '0)
		else $error("data on failed command");

endmodule

bind deque_with_indexed_read_unit dqir_checker #(
	.DEPTH(DEPTH),
	.WORD_BITS(WORD_BITS)
) u_dqir_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
